[rtl/scatr_pkg.sv]
// ----------------------------------------------------------------------------
// scatr_pkg
// Shared types, codes and helpers for the smart-card ATR parser.
// ----------------------------------------------------------------------------
package scatr_pkg;

    typedef enum logic [2:0] {
        PH_T0     = 3'd0,
        PH_TD     = 3'd1,
        PH_TA_TD  = 3'd2,
        PH_END    = 3'd3,
        PH_TA_END = 3'd4,
        PH_DONE   = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        ST_CONT = 2'd0,
        ST_DONE = 2'd1,
        ST_ERR  = 2'd2
    } t_status;

    typedef struct packed {
        t_phase      phase;
        logic [4:0]  remaining;
        logic [3:0]  hist_count;
        logic [3:0]  cycle_index;
        logic        first_proto_valid;
        logic [3:0]  first_proto;
        logic [3:0]  highest_proto;
        logic        ta1_valid;
        logic [7:0]  ta1_byte;
        logic        ta2_valid;
        logic [7:0]  ta2_byte;
    } t_state;

    typedef struct packed {
        t_status     status;
        logic        proto_valid;
        logic [3:0]  proto;
        logic        speed_valid;
        logic [7:0]  speed;
    } t_result;

    localparam logic [4:0] REMAINING_INIT = 5'd2;
    localparam logic [3:0] CYCLE_MAX      = 4'd15;
    localparam logic [7:0] PRESENCE_MASK  = 8'hF0;
    localparam int         TD_BIT         = 7;
    localparam int         TA_BIT         = 4;
    localparam int         SPEED_HOLD_BIT = 4;

    localparam t_state STATE_INIT = '{
        phase:             PH_T0,
        remaining:         REMAINING_INIT,
        hist_count:        4'd0,
        cycle_index:       4'd0,
        first_proto_valid: 1'b0,
        first_proto:       4'd0,
        highest_proto:     4'd0,
        ta1_valid:         1'b0,
        ta1_byte:          8'd0,
        ta2_valid:         1'b0,
        ta2_byte:          8'd0
    };

    // Number of interface bytes announced by the presence nibble.
    function automatic logic [2:0] presence_count(input logic [7:0] b);
        logic [7:0] m;
        m = b & PRESENCE_MASK;
        presence_count = {2'b00, m[4]} + {2'b00, m[5]} + {2'b00, m[6]} + {2'b00, m[7]};
    endfunction

endpackage

[rtl/scatr_step.sv]
// ----------------------------------------------------------------------------
// scatr_step
// Next-state and result logic for one ATR byte or restart transfer.
// ----------------------------------------------------------------------------
module scatr_step import scatr_pkg::*; (
    input  t_state     i_state,
    input  logic       i_kind,
    input  logic [7:0] i_data_byte,
    output t_state     o_state,
    output t_result    o_result
);

    t_state     s;
    t_status    st;
    logic [4:0] n;
    logic [7:0] b;
    logic       sv;

    assign b = i_data_byte;

    always_comb begin
        s  = i_state;
        st = ST_CONT;
        n  = 5'd0;
        if (i_kind) begin
            s = STATE_INIT;
        end else if (i_state.phase == PH_DONE || i_state.phase > PH_DONE) begin
            st = ST_ERR;
        end else begin
            s.remaining = i_state.remaining - 5'd1;
            if (i_state.phase == PH_TA_TD || i_state.phase == PH_TA_END) begin
                // TA capture uses the cycle number before any TD of this byte.
                if (i_state.cycle_index == 4'd1) begin
                    s.ta1_byte  = b;
                    s.ta1_valid = 1'b1;
                end else if (i_state.cycle_index == 4'd2) begin
                    s.ta2_byte  = b;
                    s.ta2_valid = 1'b1;
                end
                s.phase = (i_state.phase == PH_TA_TD) ? PH_TD : PH_END;
            end
            if (s.remaining == 5'd0) begin
                if (s.phase == PH_T0 || s.phase == PH_TD) begin
                    if (s.phase == PH_T0) begin
                        s.hist_count  = b[3:0];
                        s.cycle_index = 4'd1;
                    end else begin
                        if (s.cycle_index < CYCLE_MAX) begin
                            s.cycle_index = s.cycle_index + 4'd1;
                        end
                        if (!s.first_proto_valid) begin
                            s.first_proto_valid = 1'b1;
                            s.first_proto       = b[3:0];
                        end
                        if (b[3:0] > s.highest_proto) begin
                            s.highest_proto = b[3:0];
                        end
                    end
                    // Follow the presence bits to the next decision point.
                    n = {2'b00, presence_count(b)};
                    if (b[TD_BIT]) begin
                        s.phase = b[TA_BIT] ? PH_TA_TD : PH_TD;
                    end else begin
                        n = n + {1'b0, s.hist_count}
                              + {4'd0, (s.highest_proto != 4'd0)};
                        s.phase = b[TA_BIT] ? PH_TA_END : PH_END;
                    end
                    s.remaining = n;
                    if (n == 5'd0) begin
                        s.phase = PH_DONE;
                        st      = ST_DONE;
                    end
                end else begin
                    s.phase = PH_DONE;
                    st      = ST_DONE;
                end
            end
        end
    end

    assign sv = s.ta1_valid && s.ta2_valid && !s.ta2_byte[SPEED_HOLD_BIT];

    assign o_state              = s;
    assign o_result.status      = st;
    assign o_result.proto_valid = s.first_proto_valid;
    assign o_result.proto       = s.first_proto_valid ? s.first_proto : 4'd0;
    assign o_result.speed_valid = sv;
    assign o_result.speed       = sv ? s.ta1_byte : 8'd0;

endmodule

[rtl/smartcard_atr_parser.sv]
// ----------------------------------------------------------------------------
// smartcard_atr_parser
// Parses an answer-to-reset one byte per transfer and reports status, the
// first proposed protocol and the proposed speed byte.
// ----------------------------------------------------------------------------
// Result path: the input transfer is captured in the input register, then
// the result register is written together with the parser state.
// Throughput: one transfer per cycle while the output is not stalled.
// Reset: synchronous, active low; clears both stages and returns the parser
// to waiting for T0, as a restart transfer does.
module smartcard_atr_parser import scatr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic       i_kind,
    input  logic [7:0] i_data_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [1:0] o_status,
    output logic       o_proto_valid,
    output logic [3:0] o_proto,
    output logic       o_speed_valid,
    output logic [7:0] o_speed
);

    logic       r_in_valid;
    logic       r_kind;
    logic [7:0] r_data_byte;
    logic       r_out_valid;
    t_result    r_result;
    t_state     r_state;

    t_state     n_state;
    t_result    n_result;
    logic       advance;
    logic       in_take;

    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    scatr_step u_step (
        .i_state     (r_state),
        .i_kind      (r_kind),
        .i_data_byte (r_data_byte),
        .o_state     (n_state),
        .o_result    (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= STATE_INIT;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_kind      <= i_kind;
            r_data_byte <= i_data_byte;
        end
        if (advance) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_result.status;
    assign o_proto_valid = r_result.proto_valid;
    assign o_proto       = r_result.proto;
    assign o_speed_valid = r_result.speed_valid;
    assign o_speed       = r_result.speed;

endmodule

[tb/sv/atr_result_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atr_result_checker
// Watches both channels of the ATR parser. It runs its own parse of every
// accepted input transfer and compares each result transfer with the oldest
// pending expectation.
// ----------------------------------------------------------------------------
module atr_result_checker import scatr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  logic       i_kind,
    input  logic [7:0] i_data_byte,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  logic [1:0] i_status,
    input  logic       i_proto_valid,
    input  logic [3:0] i_proto,
    input  logic       i_speed_valid,
    input  logic [7:0] i_speed,
    output int         o_fail_count,
    output int         o_pending
);

    localparam int REPORT_LIMIT = 10;

    t_state  atr_st;
    t_result expected_results[$];
    t_result got;
    t_result want;

    task automatic log_failure(input string msg);
        o_fail_count = o_fail_count + 1;
        if (o_fail_count <= REPORT_LIMIT) begin
            $display("[%0t] %s", $realtime, msg);
        end
    endtask

    function automatic string show(input t_result r);
        return $sformatf("status=%0d proto_valid=%0b proto=%0d speed_valid=%0b speed=0x%02h",
                         r.status, r.proto_valid, r.proto, r.speed_valid, r.speed);
    endfunction

    function automatic void latch_ta(input logic [7:0] b);
        if (atr_st.cycle_index == 4'd1) begin
            atr_st.ta1_byte  = b;
            atr_st.ta1_valid = 1'b1;
        end else if (atr_st.cycle_index == 4'd2) begin
            atr_st.ta2_byte  = b;
            atr_st.ta2_valid = 1'b1;
        end
    endfunction

    // Loads the byte count for the next stretch from a T0 or TD presence nibble.
    // When no further TD follows, the historical bytes and a possible TCK are added.
    function automatic t_status follow_chain(input logic [7:0] b);
        logic [4:0] n;
        n = 5'($countones(b[7:4]));
        if (b[TD_BIT]) begin
            atr_st.phase = b[TA_BIT] ? PH_TA_TD : PH_TD;
        end else begin
            n = n + 5'(atr_st.hist_count);
            if (atr_st.highest_proto != 4'd0) begin
                n = n + 5'd1;
            end
            atr_st.phase = b[TA_BIT] ? PH_TA_END : PH_END;
        end
        atr_st.remaining = n;
        if (n == 5'd0) begin
            atr_st.phase = PH_DONE;
            return ST_DONE;
        end
        return ST_CONT;
    endfunction

    function automatic t_result parse_item(input logic kind, input logic [7:0] b);
        t_status st;
        logic    speed_ok;
        t_result r;
        if (kind) begin
            atr_st = STATE_INIT;
            st     = ST_CONT;
        end else if (atr_st.phase >= PH_DONE) begin
            st = ST_ERR;
        end else begin
            atr_st.remaining = atr_st.remaining - 5'd1;
            if (atr_st.phase == PH_TA_TD) begin
                latch_ta(b);
                atr_st.phase = PH_TD;
            end else if (atr_st.phase == PH_TA_END) begin
                latch_ta(b);
                atr_st.phase = PH_END;
            end
            if (atr_st.remaining != 5'd0) begin
                st = ST_CONT;
            end else if (atr_st.phase == PH_T0) begin
                atr_st.hist_count  = b[3:0];
                atr_st.cycle_index = 4'd1;
                st = follow_chain(b);
            end else if (atr_st.phase == PH_TD) begin
                if (atr_st.cycle_index != CYCLE_MAX) begin
                    atr_st.cycle_index = atr_st.cycle_index + 4'd1;
                end
                if (!atr_st.first_proto_valid) begin
                    atr_st.first_proto_valid = 1'b1;
                    atr_st.first_proto       = b[3:0];
                end
                if (b[3:0] > atr_st.highest_proto) begin
                    atr_st.highest_proto = b[3:0];
                end
                st = follow_chain(b);
            end else begin
                atr_st.phase = PH_DONE;
                st = ST_DONE;
            end
        end
        speed_ok      = atr_st.ta1_valid && atr_st.ta2_valid
                        && !atr_st.ta2_byte[SPEED_HOLD_BIT];
        r.status      = st;
        r.proto_valid = atr_st.first_proto_valid;
        r.proto       = atr_st.first_proto_valid ? atr_st.first_proto : 4'd0;
        r.speed_valid = speed_ok;
        r.speed       = speed_ok ? atr_st.ta1_byte : 8'd0;
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            atr_st = STATE_INIT;
            expected_results.delete();
            o_fail_count = 0;
        end else begin
            if (i_in_valid && !i_in_stall) begin
                expected_results.push_back(parse_item(i_kind, i_data_byte));
            end
            if (i_out_valid && !i_out_stall) begin
                got.status      = t_status'(i_status);
                got.proto_valid = i_proto_valid;
                got.proto       = i_proto;
                got.speed_valid = i_speed_valid;
                got.speed       = i_speed;
                if (expected_results.size() == 0) begin
                    log_failure({"unexpected result: ", show(got)});
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        log_failure({"result mismatch: expected ", show(want),
                                     " actual ", show(got)});
                    end
                end
            end
        end
        o_pending <= expected_results.size();
    end

endmodule

[tb/sv/tb_smartcard_atr_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_smartcard_atr_parser
// Feeds the ATR parser a few hand-built answers-to-reset, then random ones
// (well-formed, truncated and noisy) with random gaps and output stalls.
// A checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_smartcard_atr_parser;

    localparam int RANDOM_ITEMS = 650;
    localparam int LIMIT_CYCLES = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int IDLE_PCT     = 19;
    localparam int CALM_FIRST   = 280;
    localparam int CALM_LAST    = 440;

    localparam logic KIND_BYTE    = 1'b0;
    localparam logic KIND_RESTART = 1'b1;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       kind      = KIND_BYTE;
    logic [7:0] data_byte = 8'd0;
    logic       out_stall = 1'b0;

    logic       in_stall;
    logic       out_valid;
    logic [1:0] status;
    logic       proto_valid;
    logic [3:0] proto;
    logic       speed_valid;
    logic [7:0] speed;

    int fail_count;
    int pending;
    int sent   = 0;
    int cycles = 0;
    bit calm   = 1'b0;

    // Every first-cycle interface byte present, TB2 absent, two TD bytes with
    // protocols 1 and 15, one historical byte, then TCK.
    logic [7:0] full_atr [11] = '{8'h3F, 8'hF1, 8'h96, 8'h00, 8'hFF, 8'hD1,
                                  8'h00, 8'h0A, 8'h0F, 8'h80, 8'h55};
    // TA2 with the speed-hold bit set, so no speed is proposed.
    logic [7:0] held_atr [5]  = '{8'h3B, 8'h90, 8'h11, 8'h10, 8'h10};

    smartcard_atr_parser dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_kind        (kind),
        .i_data_byte   (data_byte),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_status      (status),
        .o_proto_valid (proto_valid),
        .o_proto       (proto),
        .o_speed_valid (speed_valid),
        .o_speed       (speed)
    );

    atr_result_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_kind        (kind),
        .i_data_byte   (data_byte),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_status      (status),
        .i_proto_valid (proto_valid),
        .i_proto       (proto),
        .i_speed_valid (speed_valid),
        .i_speed       (speed),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        out_stall <= rst_n && !calm && ($urandom_range(0, 99) < IDLE_PCT);
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Returns in the time step of the edge at which the transfer was accepted.
    task automatic put_item(input logic k, input logic [7:0] b);
        calm = (sent >= CALM_FIRST) && (sent < CALM_LAST);
        while (!calm && ($urandom_range(0, 99) < IDLE_PCT)) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        kind      <= k;
        data_byte <= b;
        @(posedge clk);
        while (in_stall) begin
            @(posedge clk);
        end
        sent++;
    endtask

    // A well-formed ATR with random content. Long TD chains are rare and can push
    // the cycle counter into saturation.
    task automatic put_atr();
        logic [7:0] atr_bytes[$];
        logic [3:0] pres;
        logic [3:0] next;
        logic [3:0] pnum;
        logic [3:0] hist;
        int         depth;
        int         max_depth;
        bit         deep;
        bit         tck_due;
        deep      = ($urandom_range(0, 9) == 0);
        max_depth = deep ? $urandom_range(13, 17) : $urandom_range(1, 4);
        hist      = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                                : 4'($urandom_range(0, 4));
        pres      = 4'($urandom_range(0, 15));
        if (deep) begin
            pres[3] = 1'b1;
        end
        tck_due = 1'b0;
        depth   = 1;
        atr_bytes.push_back(8'($urandom_range(0, 255)));
        atr_bytes.push_back({pres, hist});
        forever begin
            for (int i = 0; i < 3; i++) begin
                if (pres[i]) begin
                    atr_bytes.push_back(8'($urandom_range(0, 255)));
                end
            end
            if (!pres[3]) begin
                break;
            end
            depth++;
            next = 4'($urandom_range(0, 15));
            next[3] = deep ? (depth < max_depth) : (next[3] && depth < max_depth);
            pnum = ($urandom_range(0, 2) == 0) ? 4'd0 : 4'($urandom_range(0, 15));
            if (pnum != 4'd0) begin
                tck_due = 1'b1;
            end
            atr_bytes.push_back({next, pnum});
            pres = next;
        end
        for (int i = 0; i < hist; i++) begin
            atr_bytes.push_back(8'($urandom_range(0, 255)));
        end
        if (tck_due) begin
            atr_bytes.push_back(8'($urandom_range(0, 255)));
        end
        put_item(KIND_RESTART, 8'($urandom_range(0, 255)));
        foreach (atr_bytes[i]) begin
            put_item(KIND_BYTE, atr_bytes[i]);
        end
    endtask

    initial begin
        int start;
        int pick;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Straight out of reset, no restart: the shortest ATR, then a byte
        // after completion.
        put_item(KIND_BYTE, 8'h3B);
        put_item(KIND_BYTE, 8'h00);
        put_item(KIND_BYTE, 8'hFF);
        put_item(KIND_RESTART, 8'hFF);
        foreach (full_atr[i]) begin
            put_item(KIND_BYTE, full_atr[i]);
        end
        put_item(KIND_RESTART, 8'h00);
        foreach (held_atr[i]) begin
            put_item(KIND_BYTE, held_atr[i]);
        end

        start = sent;
        while (sent - start < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                put_atr();
                // Now and then bytes arrive after the ATR is complete.
                if ($urandom_range(0, 4) == 0) begin
                    repeat ($urandom_range(1, 2)) begin
                        put_item(KIND_BYTE, 8'($urandom_range(0, 255)));
                    end
                end
            end else if (pick < 85) begin
                put_item(KIND_RESTART, 8'($urandom_range(0, 255)));
                repeat ($urandom_range(0, 8)) begin
                    put_item(KIND_BYTE, 8'($urandom_range(0, 255)));
                end
            end else begin
                put_item(($urandom_range(0, 3) == 0) ? KIND_RESTART : KIND_BYTE,
                         8'($urandom_range(0, 255)));
            end
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
